FILE: sv/lzswd_pkg.sv
// shared types and constants of the lzss window decompressor
package lzswd_pkg;

  localparam int WINDOW_SIZE     = 4096;
  localparam int WIN_AW          = $clog2(WINDOW_SIZE);
  localparam int MAX_MATCH       = 18;
  localparam int MATCH_THRESHOLD = 2;
  localparam int LEN_W           = $clog2(MAX_MATCH + 1);
  localparam int CNT_W           = WIN_AW + 1;
  localparam int CMDQ_DEPTH      = 2;
  localparam int CMDQ_AW         = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH      = 4;
  localparam int OUTQ_AW         = $clog2(OUTQ_DEPTH);

  localparam logic [WIN_AW-1:0] WP_START   = WIN_AW'(WINDOW_SIZE - MAX_MATCH);
  localparam logic [7:0]        FILL_RESET = 8'h20;
  localparam logic [3:0]        FLAGS_FULL = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_END
  } cmd_kind_e;

  typedef enum logic {
    PH_START,
    PH_HELD_LOW
  } phase_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        lit;
    logic [WIN_AW-1:0] pos;
    logic [LEN_W-1:0]  len;
    logic              stream_end;
    logic [7:0]        fill;
  } cmd_t;

endpackage

FILE: sv/lzswd_front.sv
// front end: parses flag bytes and tokens into literal, copy and end commands
module lzswd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                push_i,
  input  lzswd_pkg::in_item_t in_i,
  output logic                full_o,
  output logic                cmd_push_o,
  output lzswd_pkg::cmd_t     cmd_o,
  input  logic                cmd_full_i
);
  import lzswd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  flag_bits_q, flag_bits_d;
  logic [3:0]  flags_left_q, flags_left_d;
  logic [7:0]  held_q, held_d;
  logic        fresh_q, fresh_d;
  logic [7:0]  stream_fill_q, stream_fill_d;
  logic [7:0]  fill_cfg_q;
  logic        accept;
  logic        has_cmd;
  logic [5:0]  len_raw;

  assign accept = push_i && !cmd_full_i;
  assign full_o = cmd_full_i;
  assign len_raw = {2'b00, in_i.data_byte[3:0]} + 6'(MATCH_THRESHOLD + 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cfg_q <= FILL_RESET;
    end else if (cfg_valid_i) begin
      fill_cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_START;
      flag_bits_q   <= '0;
      flags_left_q  <= '0;
      held_q        <= '0;
      fresh_q       <= 1'b1;
      stream_fill_q <= FILL_RESET;
    end else begin
      phase_q       <= phase_d;
      flag_bits_q   <= flag_bits_d;
      flags_left_q  <= flags_left_d;
      held_q        <= held_d;
      fresh_q       <= fresh_d;
      stream_fill_q <= stream_fill_d;
    end
  end

  always_comb begin
    phase_d          = phase_q;
    flag_bits_d      = flag_bits_q;
    flags_left_d     = flags_left_q;
    held_d           = held_q;
    fresh_d          = fresh_q;
    stream_fill_d    = stream_fill_q;
    has_cmd          = 1'b0;
    cmd_o.kind       = CMD_LIT;
    cmd_o.lit        = in_i.data_byte;
    cmd_o.pos        = {in_i.data_byte[7:4], held_q};
    cmd_o.len        = (len_raw > 6'(MAX_MATCH)) ? LEN_W'(MAX_MATCH) : len_raw[LEN_W-1:0];
    cmd_o.stream_end = in_i.last_byte;
    // the window of a new stream takes the fill value current at its first byte
    cmd_o.fill       = fresh_q ? fill_cfg_q : stream_fill_q;

    if (accept) begin
      if (fresh_q) begin
        fresh_d       = 1'b0;
        stream_fill_d = fill_cfg_q;
      end
      case (phase_q)
        PH_HELD_LOW: begin
          has_cmd      = 1'b1;
          cmd_o.kind   = CMD_COPY;
          flag_bits_d  = flag_bits_q >> 1;
          flags_left_d = flags_left_q - 4'd1;
          phase_d      = PH_START;
        end
        PH_START: begin
          if (flags_left_q == '0) begin
            flag_bits_d  = in_i.data_byte;
            flags_left_d = FLAGS_FULL;
          end else if (flag_bits_q[0]) begin
            has_cmd      = 1'b1;
            cmd_o.kind   = CMD_LIT;
            flag_bits_d  = flag_bits_q >> 1;
            flags_left_d = flags_left_q - 4'd1;
          end else begin
            held_d  = in_i.data_byte;
            phase_d = PH_HELD_LOW;
          end
        end
        default: begin
          phase_d = PH_START;
        end
      endcase
      if (in_i.last_byte) begin
        phase_d      = PH_START;
        flag_bits_d  = '0;
        flags_left_d = '0;
        held_d       = '0;
        fresh_d      = 1'b1;
        // a cut-off token still has to tell the back end the stream is over
        if (!has_cmd) begin
          has_cmd    = 1'b1;
          cmd_o.kind = CMD_END;
        end
      end
    end
  end

  assign cmd_push_o = accept && has_cmd;

endmodule

FILE: sv/lzswd_cmd_queue.sv
// small command queue between the front end and the back end
module lzswd_cmd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lzswd_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output lzswd_pkg::cmd_t cmd_o,
  output logic            empty_o
);
  import lzswd_pkg::*;

  cmd_t               entries_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
      end
      cnt_q <= cnt_q + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);
    end
  end

endmodule

FILE: sv/lzswd_back.sv
// back end: window memory, byte-per-cycle copy engine (stalls while the result queue lacks room) and result queue
module lzswd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_empty_i,
  input  lzswd_pkg::cmd_t      cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output lzswd_pkg::out_item_t out_o
);
  import lzswd_pkg::*;

  logic [7:0]         window_q [WINDOW_SIZE];
  logic [7:0]         rdata_q;

  logic [LEN_W-1:0]   k_q;
  logic [WIN_AW-1:0]  wp_q, wp_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // second stage: read data returns, byte is written back and queued
  logic               s2_valid_q;
  logic               s2_emit_q;
  logic               s2_copy_q;
  logic               s2_last_q;
  logic               s2_end_q;
  logic [7:0]         s2_lit_q;
  logic [7:0]         s2_fill_q;
  logic               s2_byp_q;
  logic [7:0]         s2_bypd_q;
  logic               s2_inwin_q;
  logic [7:0]         s2_byte;
  logic               s2_we;

  out_item_t          outq_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] oq_wr_q, oq_rd_q;
  logic [OUTQ_AW:0]   oq_cnt_q;
  logic               oq_pop;

  logic               last_elem;
  logic               space_ok;
  logic               issue;
  logic [WIN_AW-1:0]  rd_addr;
  logic [WIN_AW-1:0]  rd_offs;
  logic               rd_inwin;
  logic               rd_byp;

  assign last_elem = (cmd_i.kind != CMD_COPY) || (k_q == LEN_W'(cmd_i.len - LEN_W'(1)));
  // credit check counts the byte already in the second stage
  assign space_ok  = (oq_cnt_q + (OUTQ_AW+1)'(s2_valid_q && s2_emit_q))
                     < (OUTQ_AW+1)'(OUTQ_DEPTH);
  assign issue     = !cmd_empty_i && space_ok;
  assign cmd_pop_o = issue && last_elem;
  assign rd_addr   = cmd_i.pos + WIN_AW'(k_q);

  assign s2_byte = s2_copy_q ? (s2_byp_q   ? s2_bypd_q :
                                s2_inwin_q ? rdata_q   : s2_fill_q)
                             : s2_lit_q;
  assign s2_we   = s2_valid_q && s2_emit_q;

  always_comb begin
    wp_d    = wp_q;
    count_d = count_q;
    if (s2_we) begin
      wp_d = wp_q + WIN_AW'(1);
      if (count_q != CNT_W'(WINDOW_SIZE)) begin
        count_d = count_q + CNT_W'(1);
      end
    end
    if (s2_valid_q && s2_end_q) begin
      wp_d    = WP_START;
      count_d = '0;
    end
  end

  // entries not yet written in this stream read as the fill byte
  assign rd_offs  = rd_addr - WP_START;
  assign rd_inwin = {1'b0, rd_offs} < count_d;
  // the byte being written this cycle is not yet visible in the memory read
  assign rd_byp   = s2_we && !s2_end_q && (rd_addr == wp_q);

  always_ff @(posedge clk_i) begin
    if (s2_we) begin
      window_q[wp_q] <= s2_byte;
    end
    if (issue) begin
      rdata_q <= window_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_emit_q  <= (cmd_i.kind != CMD_END);
      s2_copy_q  <= (cmd_i.kind == CMD_COPY);
      s2_last_q  <= last_elem;
      s2_end_q   <= last_elem && cmd_i.stream_end;
      s2_lit_q   <= cmd_i.lit;
      s2_fill_q  <= cmd_i.fill;
      s2_byp_q   <= rd_byp;
      s2_bypd_q  <= s2_byte;
      s2_inwin_q <= rd_inwin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      k_q        <= '0;
      wp_q       <= WP_START;
      count_q    <= '0;
    end else begin
      s2_valid_q <= issue;
      wp_q       <= wp_d;
      count_q    <= count_d;
      if (issue) begin
        k_q <= last_elem ? '0 : k_q + LEN_W'(1);
      end
    end
  end

  assign empty_o = (oq_cnt_q == '0);
  assign oq_pop  = pop_i && !empty_o;
  assign out_o   = outq_q[oq_rd_q];

  always_ff @(posedge clk_i) begin
    if (s2_we) begin
      outq_q[oq_wr_q] <= '{out_byte: s2_byte, last_of_run: s2_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (s2_we) begin
        oq_wr_q <= oq_wr_q + OUTQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OUTQ_AW'(1);
      end
      oq_cnt_q <= oq_cnt_q + (OUTQ_AW+1)'(s2_we) - (OUTQ_AW+1)'(oq_pop);
    end
  end

endmodule

FILE: sv/lzss_window_decompressor.sv
// LZSS decoder with a 4096-byte window: top level
//
// Input queue side: one compressed byte per request, taken when push is high
// and full is low; last_byte ends the stream and returns parsing to its start.
// Result queue side: decoded bytes wait on out_o while empty is low and leave
// on pop; last_of_run marks the final byte caused by one input byte.
// Config: fill_byte on cfg_data_i, taken when cfg_valid_i is high (cfg_ready_o
// is always high); it sets the window contents for the next stream.
// Flow: a flag byte or the first byte of a reference is consumed by the
// front end alone; the back end moves one byte per cycle through the window
// memory while the result queue has room, and a reference yields 3 to 18 bytes.
// A byte's first result passes the command queue, the second stage and the
// result queue, when the command queue is empty and the result queue has room.
// The front end and the back end are split by a two-entry command queue, and
// the back end feeds a four-entry result queue; when pop stays low the result
// queue fills, the back end stops, then the command queue fills and full rises.
// Reset empties both queues, sets fill_byte to 0x20 and the write pointer to
// 4078; no clearing pass runs, unwritten window entries read as the fill byte.
module lzss_window_decompressor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [7:0]           cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  lzswd_pkg::in_item_t  in_i,
  output logic                 empty,
  input  logic                 pop,
  output lzswd_pkg::out_item_t out_o
);
  import lzswd_pkg::*;

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  cmd_t cmd_head;
  logic cmd_empty;

  assign cfg_ready_o = 1'b1;

  lzswd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .in_i       (in_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  lzswd_cmd_queue u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .cmd_o  (cmd_head),
    .empty_o(cmd_empty)
  );

  lzswd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_o      (out_o)
  );

endmodule

FILE: sv/lzswd_checker.sv
// port-level checks of the lzss window decompressor, bound to the top level
module lzswd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input lzswd_pkg::out_item_t out_o
);
  import lzswd_pkg::*;

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  // reset leaves room for a request
  a_reset_not_full: assert property (@(posedge clk_i) !rst_ni |=> !full)
    else $error("input side full after reset");

  // a waiting result holds while not popped
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("waiting result changed under stall");

  // a copy streams on: the byte after a non-final one is already there
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !out_o.last_of_run |=> !empty)
    else $error("gap inside a run of results");

endmodule

bind lzss_window_decompressor lzswd_checker u_lzswd_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .push  (push),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .out_o (out_o)
);
